### hw/rtl/sbpm_pkg.sv
// ----------------------------------------------------------------------------
// sbpm_pkg
// Types and constants shared by the servo bus packet master and its packet
// builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbpm_pkg;

    // input word codes
    localparam logic [2:0] OP_WRITE_BYTE = 3'd0;
    localparam logic [2:0] OP_WRITE_WORD = 3'd1;
    localparam logic [2:0] OP_READ_WORD  = 3'd2;
    localparam logic [2:0] OP_RX_BYTE    = 3'd3;
    localparam logic [2:0] OP_TIMEOUT    = 3'd4;

    localparam logic [1:0] KIND_READ = 2'd2;

    // protocol bytes
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] INST_READ  = 8'h02;
    localparam logic [7:0] INST_WRITE = 8'h03;
    localparam logic [7:0] READ_COUNT = 8'd2;
    localparam logic [7:0] LEN_SHORT  = 8'd4;
    localparam logic [7:0] LEN_LONG   = 8'd5;

    // packet sizes
    localparam int         PKT_MAX       = 9;
    localparam logic [3:0] PKT_LEN_SHORT = 4'd8;
    localparam logic [3:0] PKT_LEN_LONG  = 4'd9;

    // status reply layout
    localparam logic [3:0] RX_LEN_WRITE = 4'd6;
    localparam logic [3:0] RX_LEN_READ  = 4'd8;
    localparam logic [3:0] RX_POS_HDR0  = 4'd0;
    localparam logic [3:0] RX_POS_HDR1  = 4'd1;
    localparam logic [3:0] RX_POS_ID    = 4'd2;
    localparam logic [3:0] RX_POS_ERR   = 4'd4;
    localparam logic [3:0] RX_POS_VLO   = 4'd5;
    localparam logic [3:0] RX_POS_VHI   = 4'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  servo_id;
        logic [7:0]  reg_address;
        logic [15:0] write_data;
        logic [7:0]  rx_byte;
    } sbpm_in_word_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        last_of_run;
        logic        done_res;
        logic        success;
        logic [15:0] read_value;
        logic [7:0]  device_error;
        logic [31:0] success_count;
        logic [31:0] fail_count;
        logic [7:0]  last_good_id;
    } sbpm_out_word_t;

    typedef logic [PKT_MAX-1:0][7:0] sbpm_pkt_t;

endpackage

`default_nettype wire

### hw/rtl/servo_bus_packet_master.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_master
// Master side of a half-duplex servo bus transaction: instruction packet out,
// status reply in, counters and last error kept.
// ----------------------------------------------------------------------------
// usage
//   in channel  (in_valid / in_ready / in_data): one word per command, received
//     status byte or timeout event
//   out channel (out_valid / out_ready / out_data): one word per instruction
//     packet byte, or one completion word when a reply ends or times out
// latency: the first output word of an input word is valid the cycle after
//   the input is taken
// throughput: a word that yields no output or one output is taken every
//   cycle while the receiver accepts; a command holds the output buffer for
//   its 8 or 9 packet bytes, one packet byte per cycle unless the receiver
//   stalls, and the next input is taken on the cycle the checksum byte leaves
// the output buffer is the only thing between the two sides: while the
//   receiver stalls the buffer holds, in_ready stays low until its last word
//   is taken
// reset: no reply pending, counters zero, last good id 255, buffer empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module servo_bus_packet_master
    import sbpm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sbpm_in_word_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sbpm_out_word_t      out_data
);

    // transaction state
    logic        waiting_reg,  waiting_next;
    logic [1:0]  kind_reg,     kind_next;
    logic [7:0]  pid_reg,      pid_next;
    logic [3:0]  rx_idx_reg,   rx_idx_next;
    logic        hdr_ok_reg,   hdr_ok_next;
    logic [7:0]  rerr_reg,     rerr_next;
    logic [7:0]  vlo_reg,      vlo_next;
    logic [7:0]  vhi_reg,      vhi_next;
    logic [7:0]  dev_err_reg,  dev_err_next;
    logic [31:0] good_cnt_reg, good_cnt_next;
    logic [31:0] bad_cnt_reg,  bad_cnt_next;
    logic [7:0]  good_id_reg,  good_id_next;

    // output buffer: packet bytes shift out at element 0
    sbpm_pkt_t   bytes_reg,    bytes_next;
    logic [3:0]  rem_reg,      rem_next;
    logic        is_pkt_reg,   is_pkt_next;
    logic        ok_reg,       ok_next;
    logic [15:0] val_reg,      val_next;

    sbpm_pkt_t   pkt;
    logic [3:0]  pkt_len;
    logic        pop;
    logic        take;
    logic        fin;
    logic        fin_hdr;
    logic        fin_ok;
    logic [3:0]  idx_inc;
    logic [3:0]  need;
    logic        hdr_upd;

    sbpm_pkt_build u_pkt_build (
        .opcode      (in_data.opcode),
        .servo_id    (in_data.servo_id),
        .reg_address (in_data.reg_address),
        .write_data  (in_data.write_data),
        .pkt         (pkt),
        .pkt_len     (pkt_len)
    );

    assign out_valid = (rem_reg != 4'd0);
    assign pop       = out_valid && out_ready;
    // take a new word when the buffer is empty or its last word leaves now
    assign in_ready  = !out_valid || (pop && (rem_reg == 4'd1));
    assign take      = in_valid && in_ready;

    always_comb
    begin
        out_data.tx_byte       = is_pkt_reg ? bytes_reg[0] : 8'h00;
        out_data.tx_valid      = is_pkt_reg;
        out_data.last_of_run   = is_pkt_reg && (rem_reg == 4'd1);
        out_data.done_res      = !is_pkt_reg;
        out_data.success       = !is_pkt_reg && ok_reg;
        out_data.read_value    = is_pkt_reg ? 16'h0000 : val_reg;
        out_data.device_error  = dev_err_reg;
        out_data.success_count = good_cnt_reg;
        out_data.fail_count    = bad_cnt_reg;
        out_data.last_good_id  = good_id_reg;
    end

    always_comb
    begin
        waiting_next  = waiting_reg;
        kind_next     = kind_reg;
        pid_next      = pid_reg;
        rx_idx_next   = rx_idx_reg;
        hdr_ok_next   = hdr_ok_reg;
        rerr_next     = rerr_reg;
        vlo_next      = vlo_reg;
        vhi_next      = vhi_reg;
        dev_err_next  = dev_err_reg;
        good_cnt_next = good_cnt_reg;
        bad_cnt_next  = bad_cnt_reg;
        good_id_next  = good_id_reg;
        bytes_next    = bytes_reg;
        rem_next      = rem_reg;
        is_pkt_next   = is_pkt_reg;
        ok_next       = ok_reg;
        val_next      = val_reg;
        fin           = 1'b0;
        fin_hdr       = 1'b0;
        fin_ok        = 1'b0;
        idx_inc       = rx_idx_reg + 4'd1;
        need          = (kind_reg == KIND_READ) ? RX_LEN_READ : RX_LEN_WRITE;
        hdr_upd       = hdr_ok_reg;

        if (pop)
        begin
            rem_next = rem_reg - 4'd1;
            if (is_pkt_reg)
            begin
                bytes_next = {8'h00, bytes_reg[PKT_MAX-1:1]};
            end
        end

        if (take)
        begin
            case (in_data.opcode)
                OP_WRITE_BYTE, OP_WRITE_WORD, OP_READ_WORD:
                begin
                    // commands are dropped while a reply is pending
                    if (!waiting_reg)
                    begin
                        bytes_next   = pkt;
                        rem_next     = pkt_len;
                        is_pkt_next  = 1'b1;
                        waiting_next = 1'b1;
                        kind_next    = in_data.opcode[1:0];
                        pid_next     = in_data.servo_id;
                        rx_idx_next  = 4'd0;
                        hdr_ok_next  = 1'b1;
                        rerr_next    = 8'h00;
                        vlo_next     = 8'h00;
                        vhi_next     = 8'h00;
                    end
                end
                OP_RX_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        case (rx_idx_reg)
                            RX_POS_HDR0, RX_POS_HDR1:
                            begin
                                if (in_data.rx_byte != HDR_BYTE)
                                    hdr_upd = 1'b0;
                            end
                            RX_POS_ID:
                            begin
                                if (in_data.rx_byte != pid_reg)
                                    hdr_upd = 1'b0;
                            end
                            RX_POS_ERR: rerr_next = in_data.rx_byte;
                            RX_POS_VLO: vlo_next  = in_data.rx_byte;
                            RX_POS_VHI: vhi_next  = in_data.rx_byte;
                            default: ;
                        endcase
                        hdr_ok_next = hdr_upd;
                        rx_idx_next = idx_inc;
                        if (idx_inc >= need)
                        begin
                            // reply ends with its last byte: 6 bytes for a write, 8 for a read
                            fin     = 1'b1;
                            fin_hdr = hdr_upd;
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    if (waiting_reg)
                    begin
                        hdr_ok_next = 1'b0;
                        fin         = 1'b1;
                        fin_hdr     = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (fin)
        begin
            // a bad header keeps the previous device error
            if (fin_hdr)
            begin
                dev_err_next = rerr_reg;
                fin_ok       = (rerr_reg == 8'h00);
            end
            if (fin_ok)
            begin
                good_cnt_next = good_cnt_reg + 32'd1;
                good_id_next  = pid_reg;
                val_next      = (kind_reg == KIND_READ) ? {vhi_reg, vlo_reg} : 16'h0000;
            end
            else
            begin
                bad_cnt_next = bad_cnt_reg + 32'd1;
                val_next     = 16'h0000;
            end
            waiting_next = 1'b0;
            rx_idx_next  = 4'd0;
            rem_next     = 4'd1;
            is_pkt_next  = 1'b0;
            ok_next      = fin_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg  <= 1'b0;
            kind_reg     <= 2'd0;
            pid_reg      <= 8'h00;
            rx_idx_reg   <= 4'd0;
            hdr_ok_reg   <= 1'b1;
            rerr_reg     <= 8'h00;
            vlo_reg      <= 8'h00;
            vhi_reg      <= 8'h00;
            dev_err_reg  <= 8'h00;
            good_cnt_reg <= 32'd0;
            bad_cnt_reg  <= 32'd0;
            good_id_reg  <= 8'hFF;
            rem_reg      <= 4'd0;
            is_pkt_reg   <= 1'b0;
        end
        else
        begin
            waiting_reg  <= waiting_next;
            kind_reg     <= kind_next;
            pid_reg      <= pid_next;
            rx_idx_reg   <= rx_idx_next;
            hdr_ok_reg   <= hdr_ok_next;
            rerr_reg     <= rerr_next;
            vlo_reg      <= vlo_next;
            vhi_reg      <= vhi_next;
            dev_err_reg  <= dev_err_next;
            good_cnt_reg <= good_cnt_next;
            bad_cnt_reg  <= bad_cnt_next;
            good_id_reg  <= good_id_next;
            rem_reg      <= rem_next;
            is_pkt_reg   <= is_pkt_next;
        end
    end

    // buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        ok_reg    <= ok_next;
        val_reg   <= val_next;
    end

endmodule

`default_nettype wire

### hw/rtl/sbpm_pkt_build.sv
// ----------------------------------------------------------------------------
// sbpm_pkt_build
// Builds one instruction packet with its checksum from a command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbpm_pkt_build
    import sbpm_pkg::*;
(
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  servo_id,
    input  wire logic [7:0]  reg_address,
    input  wire logic [15:0] write_data,
    output sbpm_pkt_t        pkt,
    output logic [3:0]       pkt_len
);

    logic [7:0] len_byte;
    logic [7:0] inst_byte;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] sum;
    logic       long_pkt;

    always_comb
    begin
        long_pkt  = (opcode == OP_WRITE_WORD);
        len_byte  = long_pkt ? LEN_LONG : LEN_SHORT;
        inst_byte = (opcode == OP_READ_WORD) ? INST_READ : INST_WRITE;
        data0     = (opcode == OP_READ_WORD) ? READ_COUNT : write_data[7:0];
        data1     = long_pkt ? write_data[15:8] : 8'h00;
        // checksum only needs the low byte, so the sum wraps at 8 bits
        sum       = servo_id + len_byte + inst_byte + reg_address + data0 + data1;

        pkt    = '0;
        pkt[0] = HDR_BYTE;
        pkt[1] = HDR_BYTE;
        pkt[2] = servo_id;
        pkt[3] = len_byte;
        pkt[4] = inst_byte;
        pkt[5] = reg_address;
        pkt[6] = data0;
        if (long_pkt)
        begin
            pkt[7]  = data1;
            pkt[8]  = ~sum;
            pkt_len = PKT_LEN_LONG;
        end
        else
        begin
            pkt[7]  = ~sum;
            pkt_len = PKT_LEN_SHORT;
        end
    end

endmodule

`default_nettype wire
